// File: rtl/iira_pkg.sv
`default_nettype none
package iira_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int OP_W      = 3;
	localparam int ST_W      = 2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [OP_W-1:0]      opc_t;
	typedef logic [ST_W-1:0]      stat_t;

	// Operation codes.
	localparam opc_t OP_PUSH   = 3'd0;
	localparam opc_t OP_POP    = 3'd1;
	localparam opc_t OP_INSERT = 3'd2;
	localparam opc_t OP_REMOVE = 3'd3;
	localparam opc_t OP_READ   = 3'd4;
	localparam opc_t OP_WRITE  = 3'd5;

	// Status codes.
	localparam stat_t ST_OK    = 2'd0;
	localparam stat_t ST_FULL  = 2'd1;
	localparam stat_t ST_EMPTY = 2'd2;
	localparam stat_t ST_RANGE = 2'd3;

	// What the entry array does with one request.
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_UP,
		ACT_DOWN,
		ACT_WRITE
	} act_kind_t;

	// Where the result word comes from.
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_VALUE,
		SEL_STORE
	} data_sel_t;

	typedef struct packed {
		act_kind_t kind;
		idx_t      pos;
		idx_t      rd_addr;
	} arr_ctl_t;

	typedef struct packed {
		data_sel_t sel;
		stat_t     status;
		cnt_t      count;
	} res_ctl_t;

endpackage
`default_nettype wire

// File: rtl/iira_entry_array.sv
`default_nettype none
module iira_entry_array (
	input  wire                  clk,
	input  iira_pkg::arr_ctl_t   ctl,
	input  iira_pkg::word_t      wdata,
	output iira_pkg::word_t      rd_data
);
	import iira_pkg::*;

	word_t mem_q [CAPACITY];

	// Each entry picks its own next value from its neighbours or the write data.
	for (genvar k = 0; k < CAPACITY; k++) begin : g_entry
		word_t below;
		word_t above;
		logic  gt_pos;
		logic  eq_pos;
		logic  ge_pos;

		if (k > 0) begin : g_below
			assign below = mem_q[k-1];
		end else begin : g_below0
			assign below = mem_q[k];
		end
		if (k < CAPACITY - 1) begin : g_above
			assign above = mem_q[k+1];
		end else begin : g_above_top
			assign above = mem_q[k];
		end

		assign eq_pos = (idx_t'(k) == ctl.pos);
		assign gt_pos = (idx_t'(k) > ctl.pos);
		assign ge_pos = eq_pos | gt_pos;

		always_ff @(posedge clk) begin
			unique case (ctl.kind)
				ACT_UP: begin
					if (eq_pos) begin
						mem_q[k] <= wdata;
					end else if (gt_pos) begin
						mem_q[k] <= below;
					end
				end
				ACT_DOWN: begin
					if (ge_pos) begin
						mem_q[k] <= above;
					end
				end
				ACT_WRITE: begin
					if (eq_pos) begin
						mem_q[k] <= wdata;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_data = mem_q[ctl.rd_addr];

endmodule
`default_nettype wire

// File: rtl/iira_ctrl.sv
`default_nettype none
module iira_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 vld,
	input  iira_pkg::opc_t      op,
	input  iira_pkg::idx_t      index,
	output iira_pkg::arr_ctl_t  arr_ctl,
	output iira_pkg::res_ctl_t  res_ctl
);
	import iira_pkg::*;

	cnt_t count_q;
	cnt_t count_d;
	cnt_t idx_ext;
	logic full;
	logic empty;

	assign idx_ext = cnt_t'(index);
	assign full    = (count_q >= cnt_t'(CAPACITY));
	assign empty   = (count_q == '0);

	always_comb begin
		arr_ctl.kind    = ACT_NONE;
		arr_ctl.pos     = index;
		arr_ctl.rd_addr = index;
		res_ctl.sel     = SEL_ZERO;
		res_ctl.status  = ST_OK;
		count_d         = count_q;
		unique case (op)
			OP_PUSH: begin
				if (full) begin
					res_ctl.status = ST_FULL;
				end else begin
					arr_ctl.kind = ACT_UP;
					arr_ctl.pos  = count_q[IDX_W-1:0];
					res_ctl.sel  = SEL_VALUE;
					count_d      = count_q + 1'b1;
				end
			end
			OP_POP: begin
				if (empty) begin
					res_ctl.status = ST_EMPTY;
				end else begin
					count_d         = count_q - 1'b1;
					arr_ctl.rd_addr = count_d[IDX_W-1:0];
					res_ctl.sel     = SEL_STORE;
				end
			end
			OP_INSERT: begin
				if (idx_ext > count_q) begin
					res_ctl.status = ST_RANGE;
				end else if (full) begin
					res_ctl.status = ST_FULL;
				end else begin
					arr_ctl.kind = ACT_UP;
					res_ctl.sel  = SEL_VALUE;
					count_d      = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (idx_ext >= count_q) begin
					res_ctl.status = ST_RANGE;
				end else begin
					arr_ctl.kind = ACT_DOWN;
					res_ctl.sel  = SEL_STORE;
					count_d      = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (idx_ext >= count_q) begin
					res_ctl.status = ST_RANGE;
				end else begin
					res_ctl.sel = SEL_STORE;
				end
			end
			OP_WRITE: begin
				if (idx_ext >= count_q) begin
					res_ctl.status = ST_RANGE;
				end else begin
					arr_ctl.kind = ACT_WRITE;
					res_ctl.sel  = SEL_VALUE;
				end
			end
			default: begin
			end
		endcase
		if (!vld) begin
			arr_ctl.kind = ACT_NONE;
			count_d      = count_q;
		end
		res_ctl.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/indexed_insert_remove_array.sv
// Indexed insert/remove array: an ordered list of up to sixteen 32-bit words.
// A request beat is taken at a rising edge where start is high and busy is
// low; it carries op, index and value. Busy is held low throughout, since the
// block takes a new request in every cycle.
// Each request returns one result beat on data, count and status, marked by
// done being high for exactly one cycle. The request is registered, decoded
// and applied to the entry array in the next cycle, and the result is
// registered at the end of it.
// Throughput is one request per cycle; the entries shift in parallel in a
// register array, and the count register is updated in the same cycle, so
// back-to-back requests always see the state left by the one before.
// A failing request (full, empty or index out of range) leaves the array as
// it was and returns a zero data word; unused op codes do likewise with ok.
// Reset clears the entry count and the pipeline valid flags; the stored words
// are not cleared, as only entries below the count are ever read.
// The receiver cannot hold results off, so nothing here ever stalls.
`default_nettype none
module indexed_insert_remove_array (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  iira_pkg::opc_t     op,
	input  iira_pkg::idx_t     index,
	input  iira_pkg::word_t    value,
	output logic               done,
	output iira_pkg::word_t    data,
	output iira_pkg::cnt_t     count,
	output iira_pkg::stat_t    status
);
	import iira_pkg::*;

	// The request register: the first stage of the pipeline.
	logic  vld_s1;
	opc_t  op_s1;
	idx_t  index_s1;
	word_t value_s1;

	// The result register: the second stage.
	logic  done_s2;
	word_t data_s2;
	cnt_t  count_s2;
	stat_t status_s2;

	arr_ctl_t arr_ctl;
	res_ctl_t res_ctl;
	word_t    rd_data;
	word_t    data_d;
	logic     accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			done_s2 <= vld_s1;
		end
	end

	// Payload registers need no reset; they only matter alongside a valid flag.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			index_s1 <= index;
			value_s1 <= value;
		end
	end

	// Decode the request against the current count and keep the count.
	iira_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_s1),
		.op      (op_s1),
		.index   (index_s1),
		.arr_ctl (arr_ctl),
		.res_ctl (res_ctl)
	);

	// The entries themselves, with the parallel shift in either direction.
	iira_entry_array u_array (
		.clk     (clk),
		.ctl     (arr_ctl),
		.wdata   (value_s1),
		.rd_data (rd_data)
	);

	// The read happens before the shift takes effect, so a remove returns the
	// word that was at its index and a pop the word at the old back.
	always_comb begin
		unique case (res_ctl.sel)
			SEL_VALUE: data_d = value_s1;
			SEL_STORE: data_d = rd_data;
			default:   data_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			data_s2   <= data_d;
			count_s2  <= res_ctl.count;
			status_s2 <= res_ctl.status;
		end
	end

	assign done   = done_s2;
	assign data   = data_s2;
	assign count  = count_s2;
	assign status = status_s2;

endmodule
`default_nettype wire

// File: dv/iira_array_checker.sv
// Watches the request and result channels of the array, keeps its own copy of
// the entries and the fill level, and compares every result beat with the
// oldest outstanding prediction.
module iira_array_checker (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire             busy,
	input  iira_pkg::opc_t  op,
	input  iira_pkg::idx_t  index,
	input  iira_pkg::word_t value,
	input  wire             done,
	input  iira_pkg::word_t data,
	input  iira_pkg::cnt_t  count,
	input  iira_pkg::stat_t status,
	output int              fail_count,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import iira_pkg::*;

	typedef struct packed {
		word_t data;
		cnt_t  count;
		stat_t status;
	} array_result_t;

	word_t         entries [CAPACITY];
	int            held = 0;
	int            mismatches = 0;
	array_result_t awaited_results [$];

	// Applies one request to the shadow array and returns the result it gives.
	function automatic array_result_t apply_request(opc_t o, idx_t i, word_t v);
		array_result_t r;
		int pos;
		int k;
		r = '0;
		pos = int'(i);
		case (o)
		OP_PUSH: begin
			if (held >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				entries[held] = v;
				held++;
				r.data = v;
			end
		end
		OP_POP: begin
			if (held == 0) begin
				r.status = ST_EMPTY;
			end else begin
				held--;
				r.data = entries[held];
			end
		end
		OP_INSERT: begin
			// The index is checked before fullness.
			if (pos > held) begin
				r.status = ST_RANGE;
			end else if (held >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				for (k = held; k > pos; k--)
					entries[k] = entries[k - 1];
				entries[pos] = v;
				held++;
				r.data = v;
			end
		end
		OP_REMOVE: begin
			if (pos >= held) begin
				r.status = ST_RANGE;
			end else begin
				r.data = entries[pos];
				for (k = pos; k + 1 < held; k++)
					entries[k] = entries[k + 1];
				held--;
			end
		end
		OP_READ: begin
			if (pos >= held)
				r.status = ST_RANGE;
			else
				r.data = entries[pos];
		end
		OP_WRITE: begin
			if (pos >= held) begin
				r.status = ST_RANGE;
			end else begin
				entries[pos] = v;
				r.data = v;
			end
		end
		default: ;
		endcase
		r.count = cnt_t'(held);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		array_result_t want;
		if (!arst_n) begin
			held = 0;
			awaited_results.delete();
			pending <= 0;
			fail_count <= mismatches;
		end else begin
			// Predict first, so that the queue order holds whatever the latency.
			if (start && !busy)
				awaited_results.push_back(apply_request(op, index, value));
			if (done) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat: data %h count %0d status %0d",
						$time, data, count, status);
				end else begin
					want = awaited_results.pop_front();
					if (data !== want.data || count !== want.count ||
							status !== want.status) begin
						mismatches++;
						$display({"%0t: expected data %h count %0d status %0d, ",
							"actual data %h count %0d status %0d"}, $time,
							want.data, want.count, want.status, data, count, status);
					end
				end
			end
			pending <= awaited_results.size();
			fail_count <= mismatches;
		end
	end

endmodule

// File: dv/indexed_insert_remove_array_test.sv
// Top level of the array testbench. It generates the clock and the single
// reset, drives request beats into the block and gives the final verdict.
// All prediction and comparison is done in the checker instantiated beside
// the block; this module only sees how many failures it has counted and how
// many result beats it is still waiting for.
module indexed_insert_remove_array_test;
	timeunit 1ns;
	timeprecision 1ps;
	import iira_pkg::*;

	// The two op codes the block does not define; they must still return a
	// result beat with the count unchanged and an ok status.
	localparam opc_t OP_UNUSED_LO = 3'd6;
	localparam opc_t OP_UNUSED_HI = 3'd7;

	// STALL_LIMIT exceeds the longest request gap plus the time the block takes
	// to answer a request, so a quiet stretch that long can only mean a hang.
	localparam int STALL_LIMIT  = 500;
	localparam int RANDOM_BEATS = 1025;
	localparam int DRAIN_CYCLES = 4;

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	logic  start  = 1'b0;
	opc_t  op     = OP_PUSH;
	idx_t  index  = '0;
	word_t value  = '0;

	wire   busy;
	wire   done;
	word_t data;
	cnt_t  count;
	stat_t status;

	int fail_count;
	int pending;

	// A rough idea of the fill level, kept only to steer the stimulus towards
	// valid indexes; it plays no part in checking.
	int level = 0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	indexed_insert_remove_array dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.op     (op),
		.index  (index),
		.value  (value),
		.done   (done),
		.data   (data),
		.count  (count),
		.status (status)
	);

	iira_array_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.index      (index),
		.value      (value),
		.done       (done),
		.data       (data),
		.count      (count),
		.status     (status),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Watchdog: any accepted beat on either channel restarts the count. If the
	// block stops answering, the run is ended here as a failure.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Mostly back-to-back requests, a good share of short pauses and now and
	// then a long one, so that gaps land on every stage of the pipeline.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Drops start for the given number of cycles. The other request fields are
	// scrambled meanwhile, as the block must ignore them while start is low.
	task automatic idle_for(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			op    <= opc_t'($urandom);
			index <= idx_t'($urandom);
			value <= $urandom;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Presents one request beat and holds it until the edge that accepts it.
	// Start is left high, so a following beat with no gap goes straight on
	// without start ever being lowered in between.
	task automatic send_beat(opc_t o, idx_t i, word_t v);
		start <= 1'b1;
		op    <= o;
		index <= i;
		value <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		case (o)
		OP_PUSH:   if (level < CAPACITY) level++;
		OP_POP:    if (level > 0) level--;
		OP_INSERT: if (int'(i) <= level && level < CAPACITY) level++;
		OP_REMOVE: if (int'(i) < level) level--;
		default: ;
		endcase
	endtask

	initial begin
		bit    steady;
		bit    growing;
		int    roll;
		int    grow_w;
		int    shrink_w;
		int    hi;
		opc_t  o;
		idx_t  i;
		word_t v;

		steady  = 1'b0;
		growing = 1'b1;

		// Reset is applied once and released on an edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Every access on the empty array must fail: pop gives
		// empty, and remove, read and write give out of range, as does an
		// insert beyond the count.
		send_beat(OP_POP, 4'd0, 32'h1234_5678);
		send_beat(OP_REMOVE, 4'd0, 32'h0);
		send_beat(OP_READ, 4'd15, 32'hffff_ffff);
		send_beat(OP_WRITE, 4'd0, 32'hdead_beef);
		send_beat(OP_INSERT, 4'd1, 32'h0bad_cafe);

		// Insert at the front of an empty array, a push of zero, and an insert
		// whose index equals the count, which appends.
		send_beat(OP_INSERT, 4'd0, 32'hffff_ffff);
		send_beat(OP_PUSH, 4'd0, 32'h0);
		send_beat(OP_INSERT, 4'd2, 32'ha5a5_5a5a);

		// The undefined op codes leave everything as it was.
		send_beat(OP_UNUSED_LO, 4'd15, 32'hffff_ffff);
		send_beat(OP_UNUSED_HI, 4'd0, 32'h0);

		// Fill to capacity with pauses in between, then try to grow past it:
		// both a push and an in-range insert must report full.
		repeat (CAPACITY - 3) begin
			idle_for(pick_gap());
			send_beat(OP_PUSH, idx_t'($urandom), $urandom);
		end
		send_beat(OP_PUSH, 4'd0, 32'h5555_aaaa);
		send_beat(OP_INSERT, 4'd3, 32'haaaa_5555);

		// Random part. The mix swings between a growing and a shrinking phase,
		// so the level sweeps the whole range and lingers at full and empty
		// long enough to hit their error cases. Most indexes fall within the
		// current level; the rest are drawn from the whole field.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 64 == 0)
				steady = ($urandom_range(0, 3) == 0);

			if (level >= CAPACITY && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (level == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				growing = !growing;

			grow_w   = growing ? 30 : 8;
			shrink_w = growing ? 8 : 30;
			roll     = $urandom_range(0, 99);
			if (roll < grow_w)
				o = OP_PUSH;
			else if (roll < 2 * grow_w)
				o = OP_INSERT;
			else if (roll < 2 * grow_w + shrink_w)
				o = OP_POP;
			else if (roll < 2 * grow_w + 2 * shrink_w)
				o = OP_REMOVE;
			else if (roll < 2 * grow_w + 2 * shrink_w + 11)
				o = OP_READ;
			else if (roll < 2 * grow_w + 2 * shrink_w + 22)
				o = OP_WRITE;
			else
				o = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;

			// An insert may go one place past the last entry; the others may not.
			hi = (o == OP_INSERT) ? level : level - 1;
			if (hi > CAPACITY - 1)
				hi = CAPACITY - 1;
			if (hi < 0)
				hi = 0;
			if ($urandom_range(0, 99) < 80)
				i = idx_t'($urandom_range(0, hi));
			else
				i = idx_t'($urandom_range(0, CAPACITY - 1));

			roll = $urandom_range(0, 99);
			if (roll < 10)
				v = '0;
			else if (roll < 20)
				v = '1;
			else
				v = $urandom;

			idle_for(steady ? 0 : pick_gap());
			send_beat(o, i, v);
		end
		start <= 1'b0;

		// Let the last beat be counted as pending first, then wait until every result
		// beat has arrived, and a little longer to catch strays.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
